// ===== rtl/im2col_address_generator_defines.svh =====
// Assertion macros shared by the im2col address generator RTL.
// Both expect clk and rst_n in scope at the point of use.
`ifndef IM2COL_ADDRESS_GENERATOR_DEFINES_SVH
`define IM2COL_ADDRESS_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define IMCOL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IMCOL_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define IMCOL_ASSERT(label, prop, msg)
`define IMCOL_ASSERT_NEVER(label, expr, msg)
`endif
`endif

// ===== rtl/imcol_pkg.sv =====
package imcol_pkg;

    // Bounds of the configuration registers
    localparam int MAX_BATCH    = 16;
    localparam int MAX_CHANNELS = 64;
    localparam int MAX_DIM      = 1024;
    localparam int MAX_KERNEL   = 16;
    localparam int MAX_STRIDE   = 8;
    localparam int MAX_PAD      = 8;

    // Register widths
    localparam int BATCH_CFG_W = 5;
    localparam int CHAN_CFG_W  = 7;
    localparam int DIM_W       = 11;
    localparam int KERN_CFG_W  = 5;
    localparam int STRIDE_W    = 4;
    localparam int PAD_W       = 4;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_IDX_W   = 3;

    // Counter and result widths
    localparam int BATCH_W = 4;
    localparam int CHAN_W  = 6;
    localparam int KERN_W  = 4;
    localparam int COL_W   = 25;
    localparam int ROW_W   = 14;
    localparam int SRC_W   = 12;
    localparam int AREA_W  = 22;
    localparam int KAREA_W = 9;

    // Reset values of the registers and of the geometry derived from them
    localparam int BATCH_RST  = 1;
    localparam int CHAN_RST   = 1;
    localparam int H_RST      = 8;
    localparam int W_RST      = 8;
    localparam int KH_RST     = 3;
    localparam int KW_RST     = 3;
    localparam int S_RST      = 1;
    localparam int P_RST      = 0;
    localparam int OH_RST     = (H_RST + 2 * P_RST - KH_RST) / S_RST + 1;
    localparam int OW_RST     = (W_RST + 2 * P_RST - KW_RST) / S_RST + 1;
    localparam int OHOW_RST   = OH_RST * OW_RST;
    localparam int KHKW_RST   = KH_RST * KW_RST;

    // Request queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BATCH_COUNT,
        REG_CHANNEL_COUNT,
        REG_IN_HEIGHT,
        REG_IN_WIDTH,
        REG_KERNEL_HEIGHT,
        REG_KERNEL_WIDTH,
        REG_STRIDE_STEP,
        REG_PADDING
    } cfg_reg_t;

    typedef enum logic [2:0] {
        CFG_IDLE,
        CFG_LOAD,
        CFG_DIV,
        CFG_MUL,
        CFG_DONE
    } cfg_state_t;

    typedef enum logic [1:0] {
        WALK_RUN,
        WALK_FIX_ROW,
        WALK_FIX_BASE,
        WALK_FIX_SET
    } walk_state_t;

    typedef struct packed {
        logic restart;
    } item_t;

    typedef struct packed {
        logic                   busy;
        logic                   done;
        logic                   geom_ok;
        logic [BATCH_CFG_W-1:0] nb;
        logic [CHAN_CFG_W-1:0]  nc;
        logic [DIM_W-1:0]       h;
        logic [DIM_W-1:0]       w;
        logic [KERN_CFG_W-1:0]  kh;
        logic [KERN_CFG_W-1:0]  kw;
        logic [STRIDE_W-1:0]    s;
        logic [PAD_W-1:0]       p;
        logic [DIM_W-1:0]       oh;
        logic [DIM_W-1:0]       ow;
        logic [KAREA_W-1:0]     khkw;
        logic [AREA_W-1:0]      ohow;
    } geo_t;

endpackage

// ===== rtl/imcol_req_if.sv =====
interface imcol_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

// ===== rtl/imcol_res_if.sv =====
interface imcol_res_if import imcol_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    valid_res;
    logic [COL_W-1:0]        mat_col;
    logic [ROW_W-1:0]        mat_row;
    logic [BATCH_W-1:0]      batch_index;
    logic [CHAN_W-1:0]       channel_index;
    logic signed [SRC_W-1:0] src_row;
    logic signed [SRC_W-1:0] src_col;
    logic                    is_pad;
    logic                    last;

    modport source (
        output valid, output valid_res, output mat_col, output mat_row,
        output batch_index, output channel_index, output src_row, output src_col,
        output is_pad, output last, input ready
    );
    modport sink (
        input valid, input valid_res, input mat_col, input mat_row,
        input batch_index, input channel_index, input src_row, input src_col,
        input is_pad, input last, output ready
    );
endinterface

// ===== rtl/imcol_cfg.sv =====
module imcol_cfg import imcol_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output geo_t                  geo
);

    localparam int DIFF_W    = DIM_W + 1;
    localparam int REM_W     = 3;
    localparam int DIV_CNT_W = $clog2(DIM_W);

    logic [BATCH_CFG_W-1:0] batch_count_reg;
    logic [CHAN_CFG_W-1:0]  channel_count_reg;
    logic [DIM_W-1:0]       in_height_reg;
    logic [DIM_W-1:0]       in_width_reg;
    logic [KERN_CFG_W-1:0]  kernel_height_reg;
    logic [KERN_CFG_W-1:0]  kernel_width_reg;
    logic [STRIDE_W-1:0]    stride_step_reg;
    logic [PAD_W-1:0]       padding_reg;

    logic [BATCH_CFG_W-1:0] nb;
    logic [CHAN_CFG_W-1:0]  nc;
    logic [DIM_W-1:0]       h;
    logic [DIM_W-1:0]       w;
    logic [KERN_CFG_W-1:0]  kh;
    logic [KERN_CFG_W-1:0]  kw;
    logic [STRIDE_W-1:0]    s;
    logic [PAD_W-1:0]       p;

    logic [DIFF_W-1:0] ph;
    logic [DIFF_W-1:0] pw;
    logic [DIFF_W-1:0] dr;
    logic [DIFF_W-1:0] dc;
    logic              geom_ok;

    cfg_state_t state_reg;
    cfg_state_t state_next;
    logic       load_en;
    logic       div_en;
    logic       mul_en;
    logic       done_st;

    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DIM_W-1:0]     num_r_reg;
    logic [DIM_W-1:0]     num_c_reg;
    logic [REM_W-1:0]     rem_r_reg;
    logic [REM_W-1:0]     rem_c_reg;
    logic [DIM_W-1:0]     q_r1;
    logic [DIM_W-1:0]     q_c1;

    logic                 geom_ok_reg;
    logic [DIM_W-1:0]     oh_reg;
    logic [DIM_W-1:0]     ow_reg;
    logic [AREA_W-1:0]    ohow_reg;
    logic [KAREA_W-1:0]   khkw_reg;

    // One restoring step: quotient bit shifts in where the numerator bit leaves.
    function automatic logic [REM_W+DIM_W-1:0] div_step(
        input logic [REM_W-1:0]    rem,
        input logic [DIM_W-1:0]    num,
        input logic [STRIDE_W-1:0] d
    );
        logic [REM_W:0] t;
        logic           q;
        t = {rem, num[DIM_W-1]};
        q = (t >= d);
        if (q)
        begin
            t = t - d;
        end
        return {t[REM_W-1:0], num[DIM_W-2:0], q};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_count_reg   <= BATCH_CFG_W'(BATCH_RST);
            channel_count_reg <= CHAN_CFG_W'(CHAN_RST);
            in_height_reg     <= DIM_W'(H_RST);
            in_width_reg      <= DIM_W'(W_RST);
            kernel_height_reg <= KERN_CFG_W'(KH_RST);
            kernel_width_reg  <= KERN_CFG_W'(KW_RST);
            stride_step_reg   <= STRIDE_W'(S_RST);
            padding_reg       <= PAD_W'(P_RST);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BATCH_COUNT:   batch_count_reg   <= cfg_wdata[BATCH_CFG_W-1:0];
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_wdata[CHAN_CFG_W-1:0];
                REG_IN_HEIGHT:     in_height_reg     <= cfg_wdata[DIM_W-1:0];
                REG_IN_WIDTH:      in_width_reg      <= cfg_wdata[DIM_W-1:0];
                REG_KERNEL_HEIGHT: kernel_height_reg <= cfg_wdata[KERN_CFG_W-1:0];
                REG_KERNEL_WIDTH:  kernel_width_reg  <= cfg_wdata[KERN_CFG_W-1:0];
                REG_STRIDE_STEP:   stride_step_reg   <= cfg_wdata[STRIDE_W-1:0];
                REG_PADDING:       padding_reg       <= cfg_wdata[PAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Raise zero to the low bound (padding may stay zero), lower anything above the high bound
    always_comb
    begin
        nb = (batch_count_reg == '0) ? BATCH_CFG_W'(1) :
             (batch_count_reg > BATCH_CFG_W'(MAX_BATCH)) ? BATCH_CFG_W'(MAX_BATCH) :
             batch_count_reg;
        nc = (channel_count_reg == '0) ? CHAN_CFG_W'(1) :
             (channel_count_reg > CHAN_CFG_W'(MAX_CHANNELS)) ? CHAN_CFG_W'(MAX_CHANNELS) :
             channel_count_reg;
        h  = (in_height_reg == '0) ? DIM_W'(1) :
             (in_height_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : in_height_reg;
        w  = (in_width_reg == '0) ? DIM_W'(1) :
             (in_width_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : in_width_reg;
        kh = (kernel_height_reg == '0) ? KERN_CFG_W'(1) :
             (kernel_height_reg > KERN_CFG_W'(MAX_KERNEL)) ? KERN_CFG_W'(MAX_KERNEL) :
             kernel_height_reg;
        kw = (kernel_width_reg == '0) ? KERN_CFG_W'(1) :
             (kernel_width_reg > KERN_CFG_W'(MAX_KERNEL)) ? KERN_CFG_W'(MAX_KERNEL) :
             kernel_width_reg;
        s  = (stride_step_reg == '0) ? STRIDE_W'(1) :
             (stride_step_reg > STRIDE_W'(MAX_STRIDE)) ? STRIDE_W'(MAX_STRIDE) :
             stride_step_reg;
        p  = (padding_reg > PAD_W'(MAX_PAD)) ? PAD_W'(MAX_PAD) : padding_reg;
    end

    assign ph      = DIFF_W'(h) + DIFF_W'({p, 1'b0});
    assign pw      = DIFF_W'(w) + DIFF_W'({p, 1'b0});
    assign dr      = ph - DIFF_W'(kh);
    assign dc      = pw - DIFF_W'(kw);
    assign geom_ok = (ph >= DIFF_W'(kh)) && (pw >= DIFF_W'(kw));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CFG_IDLE: state_next = CFG_IDLE;
            CFG_LOAD: state_next = CFG_DIV;
            CFG_DIV:
            begin
                if (div_cnt_reg == DIV_CNT_W'(DIM_W - 1))
                begin
                    state_next = CFG_MUL;
                end
            end
            CFG_MUL:  state_next = CFG_DONE;
            CFG_DONE: state_next = CFG_IDLE;
            default:  state_next = CFG_IDLE;
        endcase
        // A new write restarts the whole setup
        if (cfg_we)
        begin
            state_next = CFG_LOAD;
        end
    end

    always_comb
    begin
        load_en = 1'b0;
        div_en  = 1'b0;
        mul_en  = 1'b0;
        done_st = 1'b0;
        unique case (state_reg)
            CFG_IDLE: ;
            CFG_LOAD: load_en = 1'b1;
            CFG_DIV:  div_en  = 1'b1;
            CFG_MUL:  mul_en  = 1'b1;
            CFG_DONE: done_st = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= CFG_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_en)
            begin
                div_cnt_reg <= '0;
            end
            else if (div_en)
            begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            num_r_reg <= dr[DIM_W-1:0];
            num_c_reg <= dc[DIM_W-1:0];
            rem_r_reg <= '0;
            rem_c_reg <= '0;
        end
        else if (div_en)
        begin
            {rem_r_reg, num_r_reg} <= div_step(rem_r_reg, num_r_reg, s);
            {rem_c_reg, num_c_reg} <= div_step(rem_c_reg, num_c_reg, s);
        end
    end

    assign q_r1 = num_r_reg + DIM_W'(1);
    assign q_c1 = num_c_reg + DIM_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_ok_reg <= 1'b1;
            oh_reg      <= DIM_W'(OH_RST);
            ow_reg      <= DIM_W'(OW_RST);
            ohow_reg    <= AREA_W'(OHOW_RST);
            khkw_reg    <= KAREA_W'(KHKW_RST);
        end
        else
        begin
            if (load_en)
            begin
                geom_ok_reg <= geom_ok;
            end
            if (mul_en)
            begin
                oh_reg   <= q_r1;
                ow_reg   <= q_c1;
                ohow_reg <= AREA_W'(q_r1) * AREA_W'(q_c1);
                khkw_reg <= KAREA_W'(kh) * KAREA_W'(kw);
            end
        end
    end

    always_comb
    begin
        geo.busy    = cfg_we || (state_reg != CFG_IDLE);
        geo.done    = done_st && !cfg_we;
        geo.geom_ok = geom_ok_reg;
        geo.nb      = nb;
        geo.nc      = nc;
        geo.h       = h;
        geo.w       = w;
        geo.kh      = kh;
        geo.kw      = kw;
        geo.s       = s;
        geo.p       = p;
        geo.oh      = oh_reg;
        geo.ow      = ow_reg;
        geo.khkw    = khkw_reg;
        geo.ohow    = ohow_reg;
    end

endmodule

// ===== rtl/imcol_front.sv =====
`include "im2col_address_generator_defines.svh"

module imcol_front import imcol_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    imcol_req_if.sink    req,
    input  logic         hold,
    input  logic         pop,
    output logic         entry_valid,
    output item_t        entry
);

    item_t              q_mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               push;

    assign req.ready   = !hold && (count_reg != Q_CNT_W'(Q_DEPTH));
    assign push        = req.valid && req.ready;
    assign entry_valid = (count_reg != '0);
    assign entry       = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= '{restart: req.restart};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
        end
    end

    `IMCOL_ASSERT(a_count_bound, count_reg <= Q_CNT_W'(Q_DEPTH), "queue count above depth")
    `IMCOL_ASSERT_NEVER(a_pop_empty, pop && (count_reg == '0), "pop from empty queue")
    `IMCOL_ASSERT(a_count_track, (push && !pop) |=> count_reg == $past(count_reg) + Q_CNT_W'(1), "count did not follow push")

endmodule

// ===== rtl/imcol_walk.sv =====
`include "im2col_address_generator_defines.svh"

module imcol_walk import imcol_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  geo_t         geo,
    input  logic         entry_valid,
    input  item_t        entry,
    output logic         pop,
    output logic         busy,
    imcol_res_if.source  res
);

    localparam int SRC_X_W = SRC_W + 1;

    typedef struct packed {
        logic               valid_res;
        logic [COL_W-1:0]   mat_col;
        logic [ROW_W-1:0]   mat_row;
        logic [BATCH_W-1:0] batch_index;
        logic [CHAN_W-1:0]  channel_index;
        logic [SRC_W-1:0]   src_row;
        logic [SRC_W-1:0]   src_col;
        logic               is_pad;
        logic               last;
    } res_t;

    walk_state_t state_reg;
    walk_state_t state_next;

    logic [BATCH_W-1:0] n_reg;
    logic [DIM_W-1:0]   oh_c_reg;
    logic [DIM_W-1:0]   ow_c_reg;
    logic [CHAN_W-1:0]  c_reg;
    logic [KERN_W-1:0]  kr_reg;
    logic [KERN_W-1:0]  kc_reg;
    logic [COL_W-1:0]   col_idx_reg;
    logic [ROW_W-1:0]   row_idx_reg;
    logic [SRC_W-1:0]   rbase_reg;
    logic [SRC_W-1:0]   cbase_reg;

    logic [COL_W-1:0]   prod_a_reg;
    logic [AREA_W-1:0]  prod_b_reg;
    logic [COL_W-1:0]   mul_a;
    logic [AREA_W-1:0]  mul_b;

    logic               out_valid_reg;
    res_t               out_reg;
    res_t               res_next;

    logic               restart;
    logic [SRC_W-1:0]   neg_p;
    logic [BATCH_W-1:0] cur_n;
    logic [DIM_W-1:0]   cur_oh;
    logic [DIM_W-1:0]   cur_ow;
    logic [CHAN_W-1:0]  cur_c;
    logic [KERN_W-1:0]  cur_kr;
    logic [KERN_W-1:0]  cur_kc;
    logic [COL_W-1:0]   cur_col;
    logic [ROW_W-1:0]   cur_row;
    logic [SRC_W-1:0]   cur_rbase;
    logic [SRC_W-1:0]   cur_cbase;

    logic kc_last, kr_last, c_last, ow_last, oh_last, n_last;
    logic step_k, step_c, step_ow, step_oh, fin;

    logic [SRC_X_W-1:0] src_r;
    logic [SRC_X_W-1:0] src_c;

    logic [BATCH_W-1:0] n_nx;
    logic [DIM_W-1:0]   oh_nx;
    logic [DIM_W-1:0]   ow_nx;
    logic [CHAN_W-1:0]  c_nx;
    logic [KERN_W-1:0]  kr_nx;
    logic [KERN_W-1:0]  kc_nx;
    logic [COL_W-1:0]   col_nx;
    logic [ROW_W-1:0]   row_nx;
    logic [SRC_W-1:0]   rbase_nx;
    logic [SRC_W-1:0]   cbase_nx;

    logic beyond;
    logic clear_walk;

    assign restart   = entry.restart;
    assign neg_p     = SRC_W'(0) - SRC_W'(geo.p);

    always_comb
    begin
        cur_n     = restart ? '0 : n_reg;
        cur_oh    = restart ? '0 : oh_c_reg;
        cur_ow    = restart ? '0 : ow_c_reg;
        cur_c     = restart ? '0 : c_reg;
        cur_kr    = restart ? '0 : kr_reg;
        cur_kc    = restart ? '0 : kc_reg;
        cur_col   = restart ? '0 : col_idx_reg;
        cur_row   = restart ? '0 : row_idx_reg;
        cur_rbase = restart ? neg_p : rbase_reg;
        cur_cbase = restart ? neg_p : cbase_reg;
    end

    always_comb
    begin
        kc_last = KERN_CFG_W'(cur_kc) == geo.kw - KERN_CFG_W'(1);
        kr_last = KERN_CFG_W'(cur_kr) == geo.kh - KERN_CFG_W'(1);
        c_last  = CHAN_CFG_W'(cur_c) == geo.nc - CHAN_CFG_W'(1);
        ow_last = cur_ow == geo.ow - DIM_W'(1);
        oh_last = cur_oh == geo.oh - DIM_W'(1);
        n_last  = BATCH_CFG_W'(cur_n) == geo.nb - BATCH_CFG_W'(1);
        step_k  = kc_last && kr_last;
        step_c  = step_k && c_last;
        step_ow = step_c && ow_last;
        step_oh = step_ow && oh_last;
        fin     = step_oh && n_last;
    end

    always_comb
    begin
        kc_nx    = kc_last ? '0 : cur_kc + KERN_W'(1);
        kr_nx    = kc_last ? (kr_last ? '0 : cur_kr + KERN_W'(1)) : cur_kr;
        c_nx     = step_k ? (c_last ? '0 : cur_c + CHAN_W'(1)) : cur_c;
        ow_nx    = step_c ? (ow_last ? '0 : cur_ow + DIM_W'(1)) : cur_ow;
        oh_nx    = step_ow ? (oh_last ? '0 : cur_oh + DIM_W'(1)) : cur_oh;
        n_nx     = step_oh ? (n_last ? '0 : cur_n + BATCH_W'(1)) : cur_n;
        row_nx   = step_c ? '0 : cur_row + ROW_W'(1);
        col_nx   = fin ? '0 : (step_c ? cur_col + COL_W'(1) : cur_col);
        rbase_nx = step_ow ? (oh_last ? neg_p : cur_rbase + SRC_W'(geo.s)) : cur_rbase;
        cbase_nx = step_c ? (ow_last ? neg_p : cur_cbase + SRC_W'(geo.s)) : cur_cbase;
    end

    // Sign-extend the base, add the kernel offset; a negative value reads as
    // a large unsigned number, so one compare against the image size covers both sides.
    assign src_r = {cur_rbase[SRC_W-1], cur_rbase} + SRC_X_W'(cur_kr);
    assign src_c = {cur_cbase[SRC_W-1], cur_cbase} + SRC_X_W'(cur_kc);

    always_comb
    begin
        res_next = '0;
        if (geo.geom_ok)
        begin
            res_next.valid_res     = 1'b1;
            res_next.mat_col       = cur_col;
            res_next.mat_row       = cur_row;
            res_next.batch_index   = cur_n;
            res_next.channel_index = cur_c;
            res_next.src_row       = src_r[SRC_W-1:0];
            res_next.src_col       = src_c[SRC_W-1:0];
            res_next.is_pad        = (src_r >= SRC_X_W'(geo.h)) || (src_c >= SRC_X_W'(geo.w));
            res_next.last          = fin;
        end
    end

    // With no valid geometry keep the counters as they are; the next request clears them
    always_comb
    begin
        beyond = (BATCH_CFG_W'(n_reg) >= geo.nb) || (oh_c_reg >= geo.oh) ||
                 (ow_c_reg >= geo.ow) || (CHAN_CFG_W'(c_reg) >= geo.nc) ||
                 (KERN_CFG_W'(kr_reg) >= geo.kh) || (KERN_CFG_W'(kc_reg) >= geo.kw);
        clear_walk = geo.geom_ok && beyond;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            WALK_RUN:
            begin
                if (geo.done && geo.geom_ok && !beyond)
                begin
                    state_next = WALK_FIX_ROW;
                end
            end
            WALK_FIX_ROW:  state_next = WALK_FIX_BASE;
            WALK_FIX_BASE: state_next = WALK_FIX_SET;
            WALK_FIX_SET:  state_next = WALK_RUN;
            default:       state_next = WALK_RUN;
        endcase
    end

    always_comb
    begin
        busy = 1'b1;
        pop  = 1'b0;
        unique case (state_reg)
            WALK_RUN:
            begin
                busy = 1'b0;
                pop  = entry_valid && (!out_valid_reg || res.ready);
            end
            WALK_FIX_ROW, WALK_FIX_BASE, WALK_FIX_SET: busy = 1'b1;
            default: busy = 1'b1;
        endcase
    end

    // Shared multipliers rebuild the running indices after a geometry change
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            WALK_RUN:
            begin
                mul_a = COL_W'(n_reg) * COL_W'(geo.ohow);
                mul_b = AREA_W'(oh_c_reg) * AREA_W'(geo.ow);
            end
            WALK_FIX_ROW:
            begin
                mul_a = COL_W'(ROW_W'(c_reg) * ROW_W'(geo.khkw));
                mul_b = AREA_W'(KAREA_W'(kr_reg) * KAREA_W'(geo.kw));
            end
            WALK_FIX_BASE:
            begin
                mul_a = COL_W'(AREA_W'(oh_c_reg) * AREA_W'(geo.s));
                mul_b = AREA_W'(ow_c_reg) * AREA_W'(geo.s);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg != WALK_FIX_SET)
        begin
            prod_a_reg <= mul_a;
            prod_b_reg <= mul_b;
        end
        if (pop)
        begin
            out_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= WALK_RUN;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
            oh_c_reg      <= '0;
            ow_c_reg      <= '0;
            c_reg         <= '0;
            kr_reg        <= '0;
            kc_reg        <= '0;
            col_idx_reg   <= '0;
            row_idx_reg   <= '0;
            rbase_reg     <= SRC_W'(0) - SRC_W'(P_RST);
            cbase_reg     <= SRC_W'(0) - SRC_W'(P_RST);
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if ((pop && !geo.geom_ok) ||
                (state_reg == WALK_RUN && geo.done && clear_walk))
            begin
                n_reg       <= '0;
                oh_c_reg    <= '0;
                ow_c_reg    <= '0;
                c_reg       <= '0;
                kr_reg      <= '0;
                kc_reg      <= '0;
                col_idx_reg <= '0;
                row_idx_reg <= '0;
                rbase_reg   <= neg_p;
                cbase_reg   <= neg_p;
            end
            else if (pop)
            begin
                n_reg       <= n_nx;
                oh_c_reg    <= oh_nx;
                ow_c_reg    <= ow_nx;
                c_reg       <= c_nx;
                kr_reg      <= kr_nx;
                kc_reg      <= kc_nx;
                col_idx_reg <= col_nx;
                row_idx_reg <= row_nx;
                rbase_reg   <= rbase_nx;
                cbase_reg   <= cbase_nx;
            end
            else
            begin
                unique case (state_reg)
                    WALK_RUN: ;
                    WALK_FIX_ROW:
                    begin
                        col_idx_reg <= prod_a_reg + COL_W'(prod_b_reg) + COL_W'(ow_c_reg);
                    end
                    WALK_FIX_BASE:
                    begin
                        row_idx_reg <= prod_a_reg[ROW_W-1:0] + prod_b_reg[ROW_W-1:0] +
                                       ROW_W'(kc_reg);
                    end
                    WALK_FIX_SET:
                    begin
                        rbase_reg <= prod_a_reg[SRC_W-1:0] - SRC_W'(geo.p);
                        cbase_reg <= prod_b_reg[SRC_W-1:0] - SRC_W'(geo.p);
                    end
                    default: ;
                endcase
            end
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.valid_res     = out_reg.valid_res;
    assign res.mat_col       = out_reg.mat_col;
    assign res.mat_row       = out_reg.mat_row;
    assign res.batch_index   = out_reg.batch_index;
    assign res.channel_index = out_reg.channel_index;
    assign res.src_row       = out_reg.src_row;
    assign res.src_col       = out_reg.src_col;
    assign res.is_pad        = out_reg.is_pad;
    assign res.last          = out_reg.last;

    `IMCOL_ASSERT(a_kern_in_bounds, (state_reg == WALK_RUN && !geo.busy && geo.geom_ok) |-> (KERN_CFG_W'(kc_reg) < geo.kw && KERN_CFG_W'(kr_reg) < geo.kh && CHAN_CFG_W'(c_reg) < geo.nc), "loop counter beyond bound")
    `IMCOL_ASSERT(a_last_wraps, (pop && res_next.last) |=> (n_reg == '0 && oh_c_reg == '0 && ow_c_reg == '0 && col_idx_reg == '0 && row_idx_reg == '0), "walk did not wrap after last")
    `IMCOL_ASSERT(a_res_hold, (res.valid && !res.ready) |=> (res.valid && $stable(out_reg)), "result changed while stalled")

endmodule

// ===== rtl/im2col_address_generator.sv =====
// im2col address generator with zero padding. Each request on req yields one result on res:
// the im2col matrix column (batch, output position) and row (channel, kernel offset) of the
// next element, its batch and channel, the signed source pixel in the unpadded image, a flag
// for elements in the zero border and a flag on the final element, after which the walk wraps;
// restart=1 returns to the first element. The loop order is batch, output row, output column,
// channel, kernel row, kernel column. Requests are taken one per cycle while req.ready is
// high, and results leave at one element per clock while res.ready is high; a small request
// queue and a result register let either side stall without stopping the other. If the kernel
// does not fit the padded image, results carry valid_res=0 and zeros. A configuration write,
// which the user must make only while the block is idle (the block does not enforce it),
// holds off requests through a load, 11 steps of the bit-serial divider that works out the
// output height and width, a multiply, a handoff, then if needed a rebuild of the running indices.
module im2col_address_generator import imcol_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    imcol_req_if.sink             req,
    imcol_res_if.source           res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    geo_t  geo;
    logic  walk_busy;
    logic  hold;
    logic  pop;
    logic  entry_valid;
    item_t entry;

    // Hold requests while the geometry settles
    assign hold = geo.busy || walk_busy;

    imcol_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .geo       (geo)
    );

    imcol_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .hold        (hold),
        .pop         (pop),
        .entry_valid (entry_valid),
        .entry       (entry)
    );

    imcol_walk u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .geo         (geo),
        .entry_valid (entry_valid),
        .entry       (entry),
        .pop         (pop),
        .busy        (walk_busy),
        .res         (res)
    );

endmodule
